>>> rtl/pdseq_pkg.sv
package pdseq_pkg;

    localparam int PHASE_COUNT = 16;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);

    typedef enum logic [PHASE_COUNT-1:0] {
        PH_INIT     = 16'h0001,
        PH_OFF      = 16'h0002,
        PH_POWER    = 16'h0004,
        PH_CLOCK    = 16'h0008,
        PH_RESET    = 16'h0010,
        PH_RELEASE  = 16'h0020,
        PH_CONNECT  = 16'h0040,
        PH_RESUME   = 16'h0080,
        PH_RUN      = 16'h0100,
        PH_DRAIN    = 16'h0200,
        PH_ISOLATE  = 16'h0400,
        PH_STOP     = 16'h0800,
        PH_FRELEASE = 16'h1000,
        PH_FAULT    = 16'h2000,
        PH_FPOWER   = 16'h4000,
        PH_FOFF     = 16'h8000
    } phase_t;

    typedef enum logic [1:0] {
        TG_OFF   = 2'd0,
        TG_RESET = 2'd1,
        TG_RUN   = 2'd2
    } target_t;

    localparam logic [PHASE_COUNT-1:0] POWERED_MASK =
        PH_CLOCK | PH_RESET | PH_RELEASE | PH_CONNECT | PH_RESUME |
        PH_RUN | PH_DRAIN | PH_ISOLATE | PH_STOP;

    localparam logic [PHASE_COUNT-1:0] FAULT_MASK =
        PH_FRELEASE | PH_FAULT | PH_FPOWER | PH_FOFF;

    typedef struct packed {
        logic       request_valid;
        logic [1:0] request_target;
        logic       obs_power;
        logic       obs_reset;
        logic       obs_isolation;
        logic       obs_idle;
        logic       service_fault;
    } in_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_now;
        logic               power_lost;
        logic               power_enable;
        logic               clock_enable;
        logic               reset_request;
        logic               isolate_request;
        logic               quiesce_request;
        logic               in_fault;
        logic               done_res;
    } out_t;

    typedef struct packed {
        logic quiesce;
        logic isolate;
        logic reset;
        logic clock;
        logic power;
    } ctrl_t;

    function automatic ctrl_t phase_ctrl(phase_t ph);
        ctrl_t c;
        c = '0;
        unique case (ph)
            PH_INIT, PH_OFF, PH_FOFF: c = '0;
            PH_POWER, PH_STOP, PH_FAULT, PH_FPOWER: begin
                c.power   = 1'b1;
                c.reset   = 1'b1;
                c.isolate = 1'b1;
                c.quiesce = 1'b1;
            end
            PH_CLOCK, PH_RESET: c = '1;
            PH_RELEASE, PH_ISOLATE: begin
                c.power   = 1'b1;
                c.clock   = 1'b1;
                c.isolate = 1'b1;
                c.quiesce = 1'b1;
            end
            PH_CONNECT, PH_DRAIN: begin
                c.power   = 1'b1;
                c.clock   = 1'b1;
                c.quiesce = 1'b1;
            end
            PH_RESUME, PH_RUN: begin
                c.power = 1'b1;
                c.clock = 1'b1;
            end
            PH_FRELEASE: begin
                c.power   = 1'b1;
                c.reset   = 1'b1;
                c.isolate = 1'b1;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
        logic [PHASE_W-1:0] code;
        code = '0;
        for (int i = 0; i < PHASE_COUNT; i++) begin
            if (ph[i]) begin
                code = code | i[PHASE_W-1:0];
            end
        end
        return code;
    endfunction

    function automatic phase_t next_phase(phase_t ph, target_t tg, logic pw, logic rs,
                                          logic iso, logic idle);
        logic   prot;
        phase_t nxt;
        prot = rs && iso;
        nxt  = ph;
        unique case (ph)
            PH_INIT: nxt = PH_OFF;
            PH_OFF: begin
                if (tg != TG_OFF && !pw && prot) nxt = PH_POWER;
            end
            PH_POWER: begin
                if (pw && prot) nxt = (tg == TG_OFF) ? PH_OFF : PH_CLOCK;
            end
            PH_CLOCK, PH_RESET: begin
                if (prot) begin
                    if (tg == TG_OFF) nxt = PH_STOP;
                    else nxt = (tg == TG_RUN) ? PH_RELEASE : PH_RESET;
                end
            end
            PH_RELEASE: begin
                if (tg != TG_RUN) nxt = PH_RESET;
                else if (!rs && iso) nxt = PH_CONNECT;
            end
            PH_CONNECT: begin
                if (!iso && idle) nxt = (tg == TG_RUN) ? PH_RESUME : PH_ISOLATE;
            end
            PH_RESUME: begin
                if (!idle) nxt = (tg == TG_RUN) ? PH_RUN : PH_DRAIN;
            end
            PH_RUN: begin
                if (tg != TG_RUN) nxt = PH_DRAIN;
            end
            PH_DRAIN: begin
                if (idle) nxt = (tg == TG_RUN) ? PH_RESUME : PH_ISOLATE;
            end
            PH_ISOLATE: begin
                if (iso) nxt = (tg == TG_RUN) ? PH_CONNECT : PH_RESET;
            end
            PH_STOP: begin
                if (prot) nxt = (tg == TG_OFF) ? PH_OFF : PH_CLOCK;
            end
            PH_FRELEASE: begin
                if (!idle) nxt = PH_FAULT;
            end
            PH_FAULT: begin
                if (prot && idle) nxt = PH_FOFF;
            end
            PH_FPOWER: begin
                if (pw) nxt = PH_FAULT;
            end
            PH_FOFF: begin
                if (tg == TG_OFF && !pw && prot) nxt = PH_OFF;
            end
            default: nxt = PH_INIT;
        endcase
        return nxt;
    endfunction

endpackage

>>> rtl/power_domain_sequencer.sv
// The result of an accepted transaction is registered in the output register.
// Throughput: one transaction per cycle; the phase and target registers are updated in the
// same cycle as the acceptance, so a new tick may follow in every cycle unless the output stalls.
// The input side stays ready while the output register is empty or being drained.
// Synchronous active-low reset sets the phase to init, the target to off, and empties the
// output register.
module power_domain_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pdseq_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pdseq_pkg::out_t   m_data
);

    pdseq_pkg::phase_t  phase_reg;
    pdseq_pkg::phase_t  phase_next;
    pdseq_pkg::target_t target_reg;
    pdseq_pkg::target_t target_next;
    logic               m_valid_reg;
    pdseq_pkg::out_t    m_data_reg;
    pdseq_pkg::out_t    m_data_next;

    logic            accept;
    logic            req_ok;
    logic            lost;
    logic            releasing;
    logic            done;
    pdseq_pkg::ctrl_t old_ctrl;
    pdseq_pkg::ctrl_t new_ctrl;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        req_ok = s_data.request_valid &&
                 (s_data.request_target == pdseq_pkg::TG_OFF ||
                  s_data.request_target == pdseq_pkg::TG_RESET ||
                  s_data.request_target == pdseq_pkg::TG_RUN);
        target_next = req_ok ? pdseq_pkg::target_t'(s_data.request_target) : target_reg;

        old_ctrl  = pdseq_pkg::phase_ctrl(phase_reg);
        lost      = (|(phase_reg & pdseq_pkg::POWERED_MASK)) && !s_data.obs_power;
        releasing = !old_ctrl.quiesce && s_data.obs_idle;

        if (s_data.service_fault && !(|(phase_reg & pdseq_pkg::FAULT_MASK))) begin
            if (phase_reg == pdseq_pkg::PH_INIT || phase_reg == pdseq_pkg::PH_OFF) begin
                phase_next = pdseq_pkg::PH_FOFF;
            end else if (phase_reg == pdseq_pkg::PH_POWER) begin
                phase_next = pdseq_pkg::PH_FPOWER;
            end else begin
                phase_next = releasing ? pdseq_pkg::PH_FRELEASE : pdseq_pkg::PH_FAULT;
            end
        end else if (lost) begin
            phase_next = releasing ? pdseq_pkg::PH_FRELEASE : pdseq_pkg::PH_FAULT;
        end else begin
            phase_next = pdseq_pkg::next_phase(phase_reg, target_next, s_data.obs_power,
                                               s_data.obs_reset, s_data.obs_isolation,
                                               s_data.obs_idle);
        end

        done = 1'b0;
        if (req_ok) begin
            case (target_next)
                pdseq_pkg::TG_OFF:
                    done = phase_next == pdseq_pkg::PH_OFF && !s_data.obs_power &&
                           s_data.obs_reset && s_data.obs_isolation && s_data.obs_idle;
                pdseq_pkg::TG_RESET:
                    done = phase_next == pdseq_pkg::PH_RESET && s_data.obs_power &&
                           s_data.obs_reset && s_data.obs_isolation && s_data.obs_idle;
                pdseq_pkg::TG_RUN:
                    done = phase_next == pdseq_pkg::PH_RUN && s_data.obs_power &&
                           !s_data.obs_reset && !s_data.obs_isolation && !s_data.obs_idle;
                default: done = 1'b0;
            endcase
        end

        new_ctrl = pdseq_pkg::phase_ctrl(phase_next);
        m_data_next.phase_now       = pdseq_pkg::phase_code(phase_next);
        m_data_next.power_lost      = lost;
        m_data_next.power_enable    = new_ctrl.power;
        m_data_next.clock_enable    = new_ctrl.clock;
        m_data_next.reset_request   = new_ctrl.reset;
        m_data_next.isolate_request = new_ctrl.isolate;
        m_data_next.quiesce_request = new_ctrl.quiesce;
        m_data_next.in_fault        = |(phase_next & pdseq_pkg::FAULT_MASK);
        m_data_next.done_res        = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= pdseq_pkg::PH_INIT;
            target_reg  <= pdseq_pkg::TG_OFF;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                target_reg  <= target_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid && m_data.phase_now == pdseq_pkg::phase_code(phase_reg))
        else $error("Result phase does not match the stored phase.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.power_lost |-> m_data.in_fault)
        else $error("Power loss did not lead into a fault phase.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.in_fault |-> !m_data.clock_enable)
        else $error("Domain clock enabled in a fault phase.");

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SQ_INIT, SQ_OFF, SQ_POWER, SQ_CLOCK, SQ_RESET, SQ_RELEASE, SQ_CONNECT, SQ_RESUME,
        SQ_RUN, SQ_DRAIN, SQ_ISOLATE, SQ_STOP, SQ_FRELEASE, SQ_FAULT, SQ_FPOWER, SQ_FOFF
    } seq_phase_e;

    localparam logic [1:0] TARGET_OFF      = pdseq_pkg::TG_OFF;
    localparam logic [1:0] TARGET_RESET    = pdseq_pkg::TG_RESET;
    localparam logic [1:0] TARGET_RUN      = pdseq_pkg::TG_RUN;
    localparam logic [1:0] TARGET_RESERVED = 2'd3;

    typedef struct packed {
        seq_phase_e         phase;
        pdseq_pkg::target_t target;
    } seq_state_t;

    typedef struct packed {
        logic            pinned;
        pdseq_pkg::out_t want;
    } pin_t;

    typedef struct packed {
        pdseq_pkg::in_t stim;
        pin_t           pin;
    } stim_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    pdseq_pkg::in_t  s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    pdseq_pkg::out_t m_data;

    seq_state_t      dut_view = {SQ_INIT, pdseq_pkg::TG_OFF};
    seq_state_t      plant_view = {SQ_INIT, pdseq_pkg::TG_OFF};
    pdseq_pkg::out_t expected_ticks[$];
    pin_t            pinned_ticks[$];
    stim_row_t       directed_rows[$];

    int items_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;
    int hold_left = 0;

    power_domain_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Control bits, most significant first: quiesce, isolate, reset, clock, power.
    function automatic pdseq_pkg::ctrl_t phase_controls(seq_phase_e p);
        case (p)
            SQ_POWER, SQ_STOP, SQ_FAULT, SQ_FPOWER: return 5'b11101;
            SQ_CLOCK, SQ_RESET:                     return 5'b11111;
            SQ_RELEASE, SQ_ISOLATE:                 return 5'b11011;
            SQ_CONNECT, SQ_DRAIN:                   return 5'b10011;
            SQ_RESUME, SQ_RUN:                      return 5'b00011;
            SQ_FRELEASE:                            return 5'b01101;
            default:                                return 5'b00000;
        endcase
    endfunction

    function automatic logic is_powered(seq_phase_e p);
        return p >= SQ_CLOCK && p <= SQ_STOP;
    endfunction

    function automatic logic is_faulted(seq_phase_e p);
        return p >= SQ_FRELEASE;
    endfunction

    function automatic seq_state_t seq_advance(seq_state_t s, pdseq_pkg::in_t t);
        seq_state_t        n;
        logic              prot;
        logic              releasing;
        pdseq_pkg::ctrl_t  c;
        n = s;
        prot = t.obs_reset && t.obs_isolation;
        c = phase_controls(s.phase);
        releasing = !c.quiesce && t.obs_idle;
        if (t.request_valid && t.request_target != TARGET_RESERVED) begin
            n.target = pdseq_pkg::target_t'(t.request_target);
        end
        if (t.service_fault && !is_faulted(s.phase)) begin
            if (s.phase == SQ_INIT || s.phase == SQ_OFF) n.phase = SQ_FOFF;
            else if (s.phase == SQ_POWER) n.phase = SQ_FPOWER;
            else n.phase = releasing ? SQ_FRELEASE : SQ_FAULT;
        end else if (is_powered(s.phase) && !t.obs_power) begin
            n.phase = releasing ? SQ_FRELEASE : SQ_FAULT;
        end else begin
            case (s.phase)
                SQ_INIT: n.phase = SQ_OFF;
                SQ_OFF: begin
                    if (n.target != pdseq_pkg::TG_OFF && !t.obs_power && prot) begin
                        n.phase = SQ_POWER;
                    end
                end
                SQ_POWER: begin
                    if (t.obs_power && prot) begin
                        n.phase = (n.target == pdseq_pkg::TG_OFF) ? SQ_OFF : SQ_CLOCK;
                    end
                end
                SQ_CLOCK, SQ_RESET: begin
                    if (prot) begin
                        if (n.target == pdseq_pkg::TG_OFF) n.phase = SQ_STOP;
                        else n.phase = (n.target == pdseq_pkg::TG_RUN) ? SQ_RELEASE : SQ_RESET;
                    end
                end
                SQ_RELEASE: begin
                    if (n.target != pdseq_pkg::TG_RUN) n.phase = SQ_RESET;
                    else if (!t.obs_reset && t.obs_isolation) n.phase = SQ_CONNECT;
                end
                SQ_CONNECT: begin
                    if (!t.obs_isolation && t.obs_idle) begin
                        n.phase = (n.target == pdseq_pkg::TG_RUN) ? SQ_RESUME : SQ_ISOLATE;
                    end
                end
                SQ_RESUME: begin
                    if (!t.obs_idle) begin
                        n.phase = (n.target == pdseq_pkg::TG_RUN) ? SQ_RUN : SQ_DRAIN;
                    end
                end
                SQ_RUN: begin
                    if (n.target != pdseq_pkg::TG_RUN) n.phase = SQ_DRAIN;
                end
                SQ_DRAIN: begin
                    if (t.obs_idle) begin
                        n.phase = (n.target == pdseq_pkg::TG_RUN) ? SQ_RESUME : SQ_ISOLATE;
                    end
                end
                SQ_ISOLATE: begin
                    if (t.obs_isolation) begin
                        n.phase = (n.target == pdseq_pkg::TG_RUN) ? SQ_CONNECT : SQ_RESET;
                    end
                end
                SQ_STOP: begin
                    if (prot) n.phase = (n.target == pdseq_pkg::TG_OFF) ? SQ_OFF : SQ_CLOCK;
                end
                SQ_FRELEASE: begin
                    if (!t.obs_idle) n.phase = SQ_FAULT;
                end
                SQ_FAULT: begin
                    if (prot && t.obs_idle) n.phase = SQ_FOFF;
                end
                SQ_FPOWER: begin
                    if (t.obs_power) n.phase = SQ_FAULT;
                end
                SQ_FOFF: begin
                    if (n.target == pdseq_pkg::TG_OFF && !t.obs_power && prot) begin
                        n.phase = SQ_OFF;
                    end
                end
            endcase
        end
        return n;
    endfunction

    function automatic pdseq_pkg::out_t seq_result(seq_state_t old_s, seq_state_t new_s,
                                                   pdseq_pkg::in_t t);
        pdseq_pkg::out_t  r;
        pdseq_pkg::ctrl_t c;
        c = phase_controls(new_s.phase);
        r.phase_now       = new_s.phase;
        r.power_lost      = is_powered(old_s.phase) && !t.obs_power;
        r.power_enable    = c.power;
        r.clock_enable    = c.clock;
        r.reset_request   = c.reset;
        r.isolate_request = c.isolate;
        r.quiesce_request = c.quiesce;
        r.in_fault        = is_faulted(new_s.phase);
        r.done_res        = 1'b0;
        if (t.request_valid && t.request_target != TARGET_RESERVED) begin
            case (pdseq_pkg::target_t'(t.request_target))
                pdseq_pkg::TG_OFF:
                    r.done_res = new_s.phase == SQ_OFF && !t.obs_power && t.obs_reset
                                 && t.obs_isolation && t.obs_idle;
                pdseq_pkg::TG_RESET:
                    r.done_res = new_s.phase == SQ_RESET && t.obs_power && t.obs_reset
                                 && t.obs_isolation && t.obs_idle;
                pdseq_pkg::TG_RUN:
                    r.done_res = new_s.phase == SQ_RUN && t.obs_power && !t.obs_reset
                                 && !t.obs_isolation && !t.obs_idle;
                default: r.done_res = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic stim_row_t dir_row(logic rv, logic [1:0] rt, logic pw, logic rs,
                                          logic iso, logic idle, logic sf,
                                          logic pinned, logic [11:0] want);
        return {rv, rt, pw, rs, iso, idle, sf, pinned, want};
    endfunction

    // Levels mostly follow what the current phase commands, with occasional upsets.
    function automatic pdseq_pkg::in_t plant_item(seq_state_t s);
        pdseq_pkg::in_t   t;
        pdseq_pkg::ctrl_t c;
        logic [7:0]       raw;
        int               sel;
        c = phase_controls(s.phase);
        raw = 8'($urandom_range(255));
        t = raw;
        if ($urandom_range(99) < 8) return t;
        sel = $urandom_range(9);
        t.request_valid = ($urandom_range(99) < 15);
        if (sel == 9) t.request_target = TARGET_RESERVED;
        else if (sel < 2) t.request_target = TARGET_OFF;
        else if (sel < 4) t.request_target = TARGET_RESET;
        else t.request_target = TARGET_RUN;
        if (is_faulted(s.phase) && $urandom_range(1) == 1) t.request_target = TARGET_OFF;
        t.obs_power     = c.power ^ ($urandom_range(99) < 2);
        t.obs_reset     = (c.power ? c.reset : 1'b1) ^ ($urandom_range(99) < 5);
        t.obs_isolation = (c.power ? c.isolate : 1'b1) ^ ($urandom_range(99) < 5);
        t.obs_idle      = c.quiesce ? ($urandom_range(9) < 8) : ($urandom_range(99) < 50);
        t.service_fault = ($urandom_range(99) < 2);
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    task automatic send_tick(input pdseq_pkg::in_t item, input pin_t pin);
        pinned_ticks.push_back(pin);
        plant_view = seq_advance(plant_view, item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_results;
        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : tick_scoreboard
        seq_state_t      next_s;
        pdseq_pkg::out_t want;
        pin_t            pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, phase %0h", m_data.phase_now));
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("phase_now", m_data.phase_now, want.phase_now);
                    check_field("power_lost", 4'(m_data.power_lost), 4'(want.power_lost));
                    check_field("power_enable", 4'(m_data.power_enable),
                                4'(want.power_enable));
                    check_field("clock_enable", 4'(m_data.clock_enable),
                                4'(want.clock_enable));
                    check_field("reset_request", 4'(m_data.reset_request),
                                4'(want.reset_request));
                    check_field("isolate_request", 4'(m_data.isolate_request),
                                4'(want.isolate_request));
                    check_field("quiesce_request", 4'(m_data.quiesce_request),
                                4'(want.quiesce_request));
                    check_field("in_fault", 4'(m_data.in_fault), 4'(want.in_fault));
                    check_field("done_res", 4'(m_data.done_res), 4'(want.done_res));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                next_s   = seq_advance(dut_view, s_data);
                want     = seq_result(dut_view, next_s, s_data);
                dut_view = next_s;
                pin      = pinned_ticks.pop_front();
                expected_ticks.push_back(pin.pinned ? pin.want : want);
            end
        end
    end

    initial begin
        // Columns: request valid, target, power, reset, isolation, idle, service fault,
        // then whether the result is given here, and the result as phase followed by
        // power lost, the five enables, fault and done.
        directed_rows.push_back(dir_row(1, TARGET_OFF,   0, 1, 1, 1, 0,
                                        1, {SQ_OFF, 8'b0000_0001}));
        directed_rows.push_back(dir_row(1, TARGET_RESERVED, 0, 1, 1, 1, 0,
                                        1, {SQ_OFF, 8'b0000_0000}));
        directed_rows.push_back(dir_row(1, TARGET_RUN,   0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 1, 0, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 0, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_RUN,   1, 0, 0, 0, 0,
                                        1, {SQ_RUN, 8'b0110_0001}));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 0, 1, 1, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_OFF,   1, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 0, 0, 0, 1,
                                        1, {SQ_FOFF, 8'b0000_0010}));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_RESET, 0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 0, 0, 0, 1, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 0, 0, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 0, 0, 0, 1, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_OFF,   0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_RESET, 0, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   1, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(1, TARGET_RESET, 1, 1, 1, 1, 0,
                                        1, {SQ_RESET, 8'b0111_1101}));
        directed_rows.push_back(dir_row(1, TARGET_OFF,   1, 1, 1, 1, 0, 0, '0));
        directed_rows.push_back(dir_row(0, TARGET_OFF,   0, 1, 1, 1, 0, 0, '0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++) begin
            send_tick(directed_rows[i].stim, directed_rows[i].pin);
        end

        for (int mode = 0; mode < 4; mode++) begin
            wait_for_results();
            case (mode)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            for (int k = 0; k < 250; k++) begin
                if (mode == 0 && k == 100) hold_len = 400;
                send_tick(plant_item(plant_view), '0);
            end
        end

        wait_for_results();
        repeat (4) @(posedge aclk);
        if (expected_ticks.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
